// ===== rtl/core/icsb_pkg.sv =====
// ----------------------------------------------------------------------------
// icsb_pkg
// Shared constants, codes and control types of the interpolating circular
// sample buffer.
// ----------------------------------------------------------------------------
`default_nettype none

package icsb_pkg;

  localparam int BUFFER_DEPTH  = 65536;
  localparam int CHANNELS      = 2;
  localparam int SAMPLE_BITS   = 24;
  localparam int FRAC_BITS     = 16;
  localparam int GUARD_ENTRIES = 512;
  localparam int MIN_DEPTH     = 4;

  localparam int POS_W   = 32;
  localparam int INT_W   = POS_W - FRAC_BITS;
  localparam int LEN_W   = 16;
  localparam int IDX_W   = $clog2(BUFFER_DEPTH);
  localparam int CH_W    = 1;
  localparam int ADDR_W  = CH_W + IDX_W;
  localparam int STORE_DEPTH = CHANNELS * BUFFER_DEPTH;
  localparam int CNT_W   = $clog2(INT_W);
  localparam int DIFF_W  = SAMPLE_BITS + 1;
  localparam int PROD_W  = DIFF_W + FRAC_BITS + 1;

  localparam int TOTAL_DEPTH = (BUFFER_DEPTH > MIN_DEPTH) ? BUFFER_DEPTH : MIN_DEPTH;
  localparam logic [LEN_W-1:0] MAX_LENGTH =
    LEN_W'((TOTAL_DEPTH > GUARD_ENTRIES) ? TOTAL_DEPTH - GUARD_ENTRIES : 1);

  // Item command codes.
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WRITE,
    ST_MOD,
    ST_RD1,
    ST_RD2,
    ST_CAP,
    ST_MUL,
    ST_OUT
  } icsb_state_t;

  typedef struct packed {
    logic take;
    logic mod_step;
    logic rd1;
    logic rd2;
    logic cap;
    logic mul;
    logic out_load;
    logic wr;
  } icsb_cmd_t;

  typedef struct packed {
    logic in_valid;
    logic in_is_read;
    logic mod_done;
    logic out_free;
  } icsb_sts_t;

endpackage

`default_nettype wire

// ===== rtl/core/icsb_if.sv =====
// ----------------------------------------------------------------------------
// icsb_if
// Valid/ready channels of the sample buffer: item input, result output and
// length configuration.
// ----------------------------------------------------------------------------
`default_nettype none

interface icsb_in_if;
  import icsb_pkg::*;

  logic                          valid;
  logic                          ready;
  logic                          cmd;
  logic [CH_W-1:0]               channel;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic [POS_W-1:0]              read_position;

  modport source (output valid, cmd, channel, sample, read_position, input ready);
  modport sink   (input valid, cmd, channel, sample, read_position, output ready);
endinterface

interface icsb_out_if;
  import icsb_pkg::*;

  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] read_value;

  modport source (output valid, read_value, input ready);
  modport sink   (input valid, read_value, output ready);
endinterface

interface icsb_cfg_if;
  import icsb_pkg::*;

  logic             valid;
  logic             ready;
  logic [LEN_W-1:0] used_length;

  modport source (output valid, used_length, input ready);
  modport sink   (input valid, used_length, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/icsb_ram.sv =====
// ----------------------------------------------------------------------------
// icsb_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module icsb_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/icsb_ctrl.sv =====
// ----------------------------------------------------------------------------
// icsb_ctrl
// Sequencer of the sample buffer: steps each word through write, or
// through modulo, two store reads, subtract, multiply and result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module icsb_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire icsb_pkg::icsb_sts_t sts,
  output      icsb_pkg::icsb_cmd_t cmd
);

  import icsb_pkg::*;

  icsb_state_t state_r;
  icsb_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        cmd.take = 1'b1;
        if (sts.in_valid) begin
          state_nxt = sts.in_is_read ? ST_MOD : ST_WRITE;
        end
      end
      ST_WRITE: begin
        cmd.wr    = 1'b1;
        state_nxt = ST_IDLE;
      end
      ST_MOD: begin
        cmd.mod_step = 1'b1;
        if (sts.mod_done) begin
          state_nxt = ST_RD1;
        end
      end
      ST_RD1: begin
        cmd.rd1   = 1'b1;
        state_nxt = ST_RD2;
      end
      ST_RD2: begin
        cmd.rd2   = 1'b1;
        state_nxt = ST_CAP;
      end
      ST_CAP: begin
        cmd.cap   = 1'b1;
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/core/icsb_dp.sv =====
// ----------------------------------------------------------------------------
// icsb_dp
// Datapath of the sample buffer: item registers, length register, write
// pointers and fill counts, bit-serial modulo, sample store, interpolator
// and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module icsb_dp (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire icsb_pkg::icsb_cmd_t cmd,
  output      icsb_pkg::icsb_sts_t sts,
  icsb_in_if.sink                  in_ch,
  icsb_out_if.source               out_ch,
  icsb_cfg_if.sink                 cfg_ch
);

  import icsb_pkg::*;

  logic [LEN_W-1:0]              len_r;
  logic [LEN_W-1:0]              len_nxt;
  logic [IDX_W-1:0]              wp_r   [CHANNELS];
  logic [IDX_W-1:0]              fill_r [CHANNELS];
  logic [CH_W-1:0]               ch_r;
  logic signed [SAMPLE_BITS-1:0] smp_r;
  logic [FRAC_BITS-1:0]          frac_r;
  logic [INT_W-1:0]              dvd_r;
  logic [IDX_W-1:0]              rem_r;
  logic [IDX_W-1:0]              rem_nxt;
  logic [CNT_W-1:0]              cnt_r;
  logic                          z1_r;
  logic                          z2_r;
  logic signed [SAMPLE_BITS-1:0] v1_r;
  logic signed [DIFF_W-1:0]      diff_r;
  logic signed [PROD_W-1:0]      prod_r;
  logic                          out_valid_r;
  logic signed [SAMPLE_BITS-1:0] out_data_r;

  logic                          accept;
  logic [IDX_W:0]                rem_sh;
  logic [IDX_W:0]                idx2_sum;
  logic [IDX_W-1:0]              idx2;
  logic [IDX_W-1:0]              wr_ptr;
  logic [IDX_W:0]                wr_inc;
  logic [IDX_W-1:0]              wp_nxt;
  logic [IDX_W-1:0]              fill_nxt;
  logic [SAMPLE_BITS-1:0]        ram_rdata;
  logic signed [SAMPLE_BITS-1:0] v2;
  logic [SAMPLE_BITS+1:0]        res_sum;

  assign accept       = cmd.take & in_ch.valid;
  assign in_ch.ready  = cmd.take;
  assign cfg_ch.ready = 1'b1;

  assign sts.in_valid   = in_ch.valid;
  assign sts.in_is_read = (in_ch.cmd == CMD_READ);
  assign sts.mod_done   = (cnt_r == '0);
  assign sts.out_free   = ~out_valid_r | out_ch.ready;

  // Written lengths are clamped into the usable range.
  always_comb begin
    if (cfg_ch.used_length == '0) begin
      len_nxt = LEN_W'(1);
    end else if (cfg_ch.used_length > MAX_LENGTH) begin
      len_nxt = MAX_LENGTH;
    end else begin
      len_nxt = cfg_ch.used_length;
    end
  end

  // One restoring step of the integer position modulo the used length.
  always_comb begin
    rem_sh = {rem_r, dvd_r[INT_W-1]};
    if (rem_sh >= {1'b0, len_r}) begin
      rem_nxt = IDX_W'(rem_sh - {1'b0, len_r});
    end else begin
      rem_nxt = rem_sh[IDX_W-1:0];
    end
  end

  // The second index follows the first and wraps at the used length.
  assign idx2_sum = {1'b0, rem_r} + (IDX_W+1)'(1);
  assign idx2     = (idx2_sum == {1'b0, len_r}) ? '0 : idx2_sum[IDX_W-1:0];

  // A pointer left beyond a shortened length restarts at entry zero.
  assign wr_ptr   = (wp_r[ch_r] >= len_r) ? '0 : wp_r[ch_r];
  assign wr_inc   = {1'b0, wr_ptr} + (IDX_W+1)'(1);
  assign wp_nxt   = (wr_inc >= {1'b0, len_r}) ? '0 : wr_inc[IDX_W-1:0];
  assign fill_nxt = (wr_inc > {1'b0, fill_r[ch_r]}) ? wr_inc[IDX_W-1:0] : fill_r[ch_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= MAX_LENGTH;
      for (int c = 0; c < CHANNELS; c++) begin
        wp_r[c]   <= '0;
        fill_r[c] <= '0;
      end
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_ch.valid) begin
        len_r <= len_nxt;
      end
      if (cmd.wr) begin
        wp_r[ch_r]   <= wp_nxt;
        fill_r[ch_r] <= fill_nxt;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ch_r   <= in_ch.channel;
      smp_r  <= in_ch.sample;
      frac_r <= in_ch.read_position[FRAC_BITS-1:0];
      dvd_r  <= in_ch.read_position[POS_W-1:FRAC_BITS];
      rem_r  <= '0;
      cnt_r  <= CNT_W'(INT_W - 1);
    end else if (cmd.mod_step) begin
      dvd_r <= {dvd_r[INT_W-2:0], 1'b0};
      rem_r <= rem_nxt;
      cnt_r <= cnt_r - CNT_W'(1);
    end
  end

  // Entries at or above a channel's fill count have never been written
  // since reset and read as zero.
  assign v2 = z2_r ? '0 : $signed(ram_rdata);

  always_ff @(posedge clk) begin
    if (cmd.rd1) begin
      z1_r <= (rem_r >= fill_r[ch_r]);
    end
    if (cmd.rd2) begin
      v1_r <= z1_r ? '0 : $signed(ram_rdata);
      z2_r <= (idx2 >= fill_r[ch_r]);
    end
    if (cmd.cap) begin
      diff_r <= DIFF_W'(v2) - DIFF_W'(v1_r);
    end
    if (cmd.mul) begin
      prod_r <= $signed({1'b0, frac_r}) * diff_r;
    end
    if (cmd.out_load) begin
      out_data_r <= res_sum[SAMPLE_BITS-1:0];
    end
  end

  // Dropping the fraction bits of a signed product floors the step.
  assign res_sum = {{2{v1_r[SAMPLE_BITS-1]}}, v1_r} + prod_r[PROD_W-1:FRAC_BITS];

  assign out_ch.valid      = out_valid_r;
  assign out_ch.read_value = out_data_r;

  icsb_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (cmd.wr),
    .waddr ({ch_r, wr_ptr}),
    .wdata (smp_r),
    .re    (cmd.rd1 | cmd.rd2),
    .raddr (cmd.rd1 ? {ch_r, rem_r} : {ch_r, idx2}),
    .rdata (ram_rdata)
  );

  a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
    (len_r != '0) && (len_r <= MAX_LENGTH))
    else $error("used length outside its clamped range");

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd1 |-> (rem_r < len_r))
    else $error("modulo result not below the used length");

  a_wp_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr |=> (wp_r[ch_r] < len_r))
    else $error("write pointer left at or past the used length");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr |=> (fill_r[ch_r] <= MAX_LENGTH) && (fill_r[ch_r] != '0))
    else $error("fill count out of range after a write");

endmodule

`default_nettype wire

// ===== rtl/core/interpolating_circular_sample_buffer_unit.sv =====
// ----------------------------------------------------------------------------
// interpolating_circular_sample_buffer_unit
// Two-channel circular sample store with linearly interpolated reads.
// ----------------------------------------------------------------------------
// A write word stores its sample at the channel's write pointer, which then
// advances and wraps at the used length; the word is accepted, then stored.
// A read word is accepted, then its integer position is reduced modulo the
// used length bit-serially, one quotient bit per cycle. Two store reads
// through the single read port, one subtract and one multiply follow, and
// the result is loaded into the output register once the previous result
// is no longer held. The block takes no new word while one is in flight;
// the next word is accepted in the cycle after the result is loaded.
// Each channel keeps a fill count of the entries written since reset, so the
// store needs no clearing pass and the block is ready straight after reset.
// The used length may only be written while no word is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module interpolating_circular_sample_buffer_unit (
  input  wire logic  clk,
  input  wire logic  rst_n,
  icsb_in_if.sink    in_ch,
  icsb_out_if.source out_ch,
  icsb_cfg_if.sink   cfg_ch
);

  import icsb_pkg::*;

  icsb_cmd_t cmd;
  icsb_sts_t sts;

  icsb_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .sts   (sts),
    .cmd   (cmd)
  );

  icsb_dp u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd    (cmd),
    .sts    (sts),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

endmodule

`default_nettype wire

// ===== dv/interpolating_circular_sample_buffer_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// interpolating_circular_sample_buffer_unit_tb
// Self-checking bench for the two-channel circular sample buffer. Sample and
// read words go in through a queue-fed driver. A shadow copy of the store,
// the write pointers and the used length predicts every interpolated read,
// and a monitor compares each result word with the oldest prediction. The
// run steps through several used lengths under varied gaps and stalls.
// ----------------------------------------------------------------------------

module interpolating_circular_sample_buffer_unit_tb;

  import icsb_pkg::*;

  typedef struct packed {
    logic                         cmd;
    logic                         channel;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic [POS_W-1:0]             read_position;
  } sample_word_t;

  localparam int HOLD_CYCLES     = 400;
  localparam int SETTLE_CYCLES   = 40;
  localparam int PHASES          = 8;
  localparam int WORDS_PER_PHASE = 106;

  logic clk = 1'b0;
  logic rst_n;

  icsb_in_if  in_if ();
  icsb_out_if out_if ();
  icsb_cfg_if cfg_if ();

  interpolating_circular_sample_buffer_unit u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  // Shadow state of the block.
  logic signed [SAMPLE_BITS-1:0] shadow_store [CHANNELS][BUFFER_DEPTH];
  int unsigned                   shadow_ptr [CHANNELS];
  int unsigned                   shadow_length;

  sample_word_t                  word_queue [$];
  logic signed [SAMPLE_BITS-1:0] interp_expected [$];
  sample_word_t                  next_word;
  logic signed [SAMPLE_BITS-1:0] oldest_value;

  int   send_idle_pct  = 0;
  int   recv_stall_pct = 0;
  logic hold_off       = 1'b0;
  logic in_taken       = 1'b0;
  event stall_burst;

  int n_errors  = 0;
  int n_writes  = 0;
  int n_reads   = 0;
  int n_checked = 0;
  int n_lengths = 0;

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("Timeout: %0d read results still outstanding", interp_expected.size());
    $display("Simulation FAILED");
    $finish;
  end

  function automatic void store_sample(logic ch, logic signed [SAMPLE_BITS-1:0] s);
    int unsigned p;
    p = shadow_ptr[ch];
    // A pointer left beyond a shortened length restarts at entry zero.
    if (p >= shadow_length) p = 0;
    shadow_store[ch][p] = s;
    p++;
    if (p >= shadow_length) p = 0;
    shadow_ptr[ch] = p;
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] interpolate(logic ch,
                                                                logic [POS_W-1:0] pos);
    longint unsigned i1, i2;
    longint          v1, v2, frac, prod;
    i1 = pos[POS_W-1:FRAC_BITS];
    i2 = i1 + 1;
    if (i2 >= shadow_length) begin
      i1 = i1 % shadow_length;
      i2 = i2 % shadow_length;
    end
    v1   = shadow_store[ch][i1];
    v2   = shadow_store[ch][i2];
    frac = longint'(pos[FRAC_BITS-1:0]);
    prod = frac * (v2 - v1);
    // The arithmetic shift floors, so negative steps round towards minus infinity.
    return SAMPLE_BITS'(v1 + (prod >>> FRAC_BITS));
  endfunction

  function automatic sample_word_t write_word(logic ch, logic signed [SAMPLE_BITS-1:0] s);
    sample_word_t w;
    w.cmd           = CMD_WRITE;
    w.channel       = ch;
    w.sample        = s;
    w.read_position = $urandom;
    return w;
  endfunction

  function automatic sample_word_t read_word(logic ch, logic [POS_W-1:0] pos);
    sample_word_t w;
    w.cmd           = CMD_READ;
    w.channel       = ch;
    w.sample        = SAMPLE_BITS'($urandom);
    w.read_position = pos;
    return w;
  endfunction

  task automatic set_length(input logic [LEN_W-1:0] value);
    @(negedge clk);
    cfg_if.valid       <= 1'b1;
    cfg_if.used_length <= value;
    do @(posedge clk); while (!cfg_if.ready);
    if (value == 0) shadow_length = 1;
    else if (value > MAX_LENGTH) shadow_length = MAX_LENGTH;
    else shadow_length = value;
    n_lengths++;
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  // Waits at rising edges so that a word popped at the falling edge is seen as valid.
  task automatic settle();
    while (word_queue.size() != 0 || in_if.valid || interp_expected.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Input driver: a word stays offered until it is taken.
  always @(negedge clk) begin
    if (rst_n && (!in_if.valid || in_taken)) begin
      if (word_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        next_word              = word_queue.pop_front();
        in_if.valid           <= 1'b1;
        in_if.cmd             <= next_word.cmd;
        in_if.channel         <= next_word.channel;
        in_if.sample          <= next_word.sample;
        in_if.read_position   <= next_word.read_position;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    out_if.ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
  end

  always begin
    @(stall_burst);
    @(posedge clk);
    hold_off = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off = 1'b0;
  end

  always @(posedge clk) begin
    in_taken <= in_if.valid && in_if.ready;
    if (rst_n) begin
      if (in_if.valid && in_if.ready) begin
        if (in_if.cmd == CMD_WRITE) begin
          store_sample(in_if.channel, in_if.sample);
          n_writes++;
        end else begin
          interp_expected.push_back(interpolate(in_if.channel, in_if.read_position));
          n_reads++;
        end
      end
      if (out_if.valid && out_if.ready) begin
        if (interp_expected.size() == 0) begin
          $display("%0t: read_value %0d arrived with no read outstanding",
                   $time, out_if.read_value);
          n_errors++;
        end else begin
          oldest_value = interp_expected.pop_front();
          n_checked++;
          if (out_if.read_value !== oldest_value) begin
            $display("%0t: read_value mismatch: expected %0d, actual %0d",
                     $time, oldest_value, out_if.read_value);
            n_errors++;
          end
        end
      end
    end
  end

  initial begin
    logic [LEN_W-1:0]              lengths [PHASES];
    logic signed [SAMPLE_BITS-1:0] s;
    logic [POS_W-1:0]              pos;
    int unsigned                   window, idx;
    int                            sel;

    in_if.valid         = 1'b0;
    in_if.cmd           = CMD_WRITE;
    in_if.channel       = 1'b0;
    in_if.sample        = '0;
    in_if.read_position = '0;
    out_if.ready        = 1'b0;
    cfg_if.valid        = 1'b0;
    cfg_if.used_length  = '0;
    rst_n               = 1'b0;

    for (int ch = 0; ch < CHANNELS; ch++) begin
      for (int i = 0; i < BUFFER_DEPTH; i++) shadow_store[ch][i] = '0;
      shadow_ptr[ch] = 0;
    end
    shadow_length = MAX_LENGTH;

    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    // Full length straight out of reset: extremes, truncation and top-end wrapping.
    word_queue.push_back(read_word(1'b0, 32'h0000_0000));
    word_queue.push_back(write_word(1'b0, 24'sh7FFFFF));
    word_queue.push_back(write_word(1'b0, 24'sh800000));
    word_queue.push_back(write_word(1'b0, 24'sh000000));
    word_queue.push_back(write_word(1'b0, 24'shFFFFFF));
    word_queue.push_back(write_word(1'b1, 24'sd1234));
    word_queue.push_back(write_word(1'b1, -24'sd5));
    word_queue.push_back(read_word(1'b0, 32'h0000_0000));
    word_queue.push_back(read_word(1'b0, 32'h0000_FFFF));
    word_queue.push_back(read_word(1'b0, 32'h0001_8000));
    word_queue.push_back(read_word(1'b0, 32'h0002_0001));
    word_queue.push_back(read_word(1'b0, 32'h0003_FFFF));
    word_queue.push_back(read_word(1'b1, 32'h0000_C000));
    word_queue.push_back(read_word(1'b0, 32'hFFFF_FFFF));
    word_queue.push_back(read_word(1'b0, {16'(MAX_LENGTH - 1), 16'h8000}));
    settle();

    // A zero length clamps to one, leaving the channel 0 pointer beyond it.
    set_length(16'h0000);
    word_queue.push_back(write_word(1'b0, 24'sd77));
    word_queue.push_back(read_word(1'b0, 32'h0005_8000));
    word_queue.push_back(read_word(1'b1, 32'h0000_0000));
    settle();

    set_length(16'hFFFF);
    word_queue.push_back(read_word(1'b0, 32'h0000_4000));
    word_queue.push_back(write_word(1'b1, 24'sh800000));
    word_queue.push_back(read_word(1'b1, 32'h0000_8000));
    settle();

    lengths = '{16'd2, 16'd5, 16'd17, 16'd1, 16'd300, MAX_LENGTH, 16'd9, 16'd64};
    lengths[6] = LEN_W'($urandom_range(3, 40));

    for (int p = 0; p < PHASES; p++) begin
      set_length(lengths[p]);
      @(posedge clk);
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 69; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 69; end
        default: begin send_idle_pct = 18; recv_stall_pct = 18; end
      endcase
      // The output is held off for a long stretch so that the input backs up.
      if (p == 4) -> stall_burst;
      window = (shadow_length < 256) ? shadow_length + 1 : 256;
      for (int k = 0; k < WORDS_PER_PHASE; k++) begin
        if ($urandom_range(99) < 55) begin
          if ($urandom_range(9) == 0) s = $urandom_range(1) ? 24'sh7FFFFF : 24'sh800000;
          else s = SAMPLE_BITS'($urandom);
          word_queue.push_back(write_word(1'($urandom), s));
        end else begin
          sel = $urandom_range(99);
          idx = $urandom_range(window);
          if (sel < 80) pos = {idx[15:0], 16'($urandom)};
          else if (sel < 90) pos = {idx[15:0], ($urandom_range(1) ? 16'hFFFF : 16'h0000)};
          else pos = $urandom;
          word_queue.push_back(read_word(1'($urandom), pos));
        end
      end
      settle();
    end

    $display("Covered %0d sample writes and %0d checked interpolated reads over %0d lengths,",
             n_writes, n_checked, n_lengths);
    $display("with sender gaps, receiver stalls and one long output hold-off.");
    if (n_errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches found", n_errors);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
